FILE: hw/rtl/ntm_pkg.sv
package ntm_pkg;

  localparam int STAMP_W    = 63;
  localparam int TAG_PORT_W = 16;
  localparam int REG_W      = 32;
  localparam int DROP_W     = 7;
  localparam int DIFF_W     = REG_W + 1;

  localparam int DEPTH_DEFAULT    = 64;
  localparam int TAG_BITS_DEFAULT = 16;

  localparam logic [REG_W-1:0]  TOL_RESET   = 32'd10000000;
  localparam logic [REG_W-1:0]  STALE_RESET = 32'd100000000;
  localparam logic [DROP_W-1:0] DROP_MAX    = 7'd127;

  // configuration register indexes
  localparam logic REG_MATCH_TOLERANCE = 1'b0;
  localparam logic REG_STALE_AGE       = 1'b1;

  // opcodes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_SHIFT  = 2'd1,
    CELL_ROTATE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     wr_en;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/nearest_timestamp_matcher.sv
// Timestamp matcher over a row of DEPTH cells kept in arrival order, oldest
// in cell 0. A push is taken while busy stays low and its result strobes
// on done in the next cycle. A query holds busy high while the row rotates
// once through a two-stage compare unit, one entry per cycle, and then
// shifts out one removed entry per cycle. The result strobes on done for
// one cycle right after busy falls; it cannot be held off, so capture it
// when done is high. Configuration writes belong to idle periods.
module nearest_timestamp_matcher #(
  parameter int DEPTH    = ntm_pkg::DEPTH_DEFAULT,
  parameter int TAG_BITS = ntm_pkg::TAG_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            opcode,
  input  logic [ntm_pkg::STAMP_W-1:0]     stamp,
  input  logic [ntm_pkg::TAG_PORT_W-1:0]  tag,
  input  logic                            cfg_write,
  input  logic                            cfg_index,
  input  logic [ntm_pkg::REG_W-1:0]       cfg_data,
  output logic                            done,
  output logic                            found,
  output logic [ntm_pkg::TAG_PORT_W-1:0]  match_tag,
  output logic [ntm_pkg::STAMP_W-1:0]     match_stamp,
  output logic [ntm_pkg::DROP_W-1:0]      dropped_count,
  output logic                            overflow
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SW    = ntm_pkg::STAMP_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DROP  = 4'b1000
  } state_t;

  state_t state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] drop_left;
  logic [ntm_pkg::REG_W-1:0] match_tolerance;
  logic [ntm_pkg::REG_W-1:0] stale_age;

  logic accept;
  logic full;
  logic issue;
  ntm_pkg::cell_ctrl_t cell_ctrl;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] last_idx;
  logic [CNT_W-1:0] count_dec;
  logic [31:0] tag_wide;
  logic [TAG_BITS-1:0] new_tag;

  logic [SW-1:0]       cell_stamp [DEPTH];
  logic [TAG_BITS-1:0] cell_tag   [DEPTH];

  logic                have;
  logic [IDX_W-1:0]    best_pos;
  logic [SW-1:0]       best_stamp;
  logic [TAG_BITS-1:0] best_tag;
  logic [CNT_W-1:0]    stale_n;
  logic [CNT_W-1:0]    drop_n;
  logic [31:0]         best_tag_wide;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign full      = (count == CNT_W'(DEPTH));
  assign issue     = (state == S_SCAN) && (scan_idx != count);
  assign count_dec = count - CNT_W'(1);
  assign last_idx  = count_dec[IDX_W-1:0];
  assign tag_wide  = 32'(tag);
  assign new_tag   = tag_wide[TAG_BITS-1:0];
  assign best_tag_wide = 32'(best_tag);
  assign drop_n    = have ? (CNT_W'(best_pos) + CNT_W'(1)) : stale_n;

  always_comb begin
    cell_ctrl.op    = ntm_pkg::CELL_HOLD;
    cell_ctrl.wr_en = 1'b0;
    wr_idx          = count[IDX_W-1:0];
    if (accept && (opcode == ntm_pkg::OP_PUSH)) begin
      cell_ctrl.wr_en = 1'b1;
      if (full) begin
        // oldest falls off the front, new entry enters at the tail
        cell_ctrl.op = ntm_pkg::CELL_SHIFT;
        wr_idx       = IDX_W'(DEPTH - 1);
      end
    end else if (issue) begin
      cell_ctrl.op = ntm_pkg::CELL_ROTATE;
    end else if ((state == S_DROP) && (drop_left != '0)) begin
      cell_ctrl.op = ntm_pkg::CELL_SHIFT;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int NXT = (i == DEPTH - 1) ? i : i + 1;
    ntm_cell #(
      .IDX      (i),
      .IDX_W    (IDX_W),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .wr_idx     (wr_idx),
      .last_idx   (last_idx),
      .wr_stamp   (stamp),
      .wr_tag     (new_tag),
      .next_stamp (cell_stamp[NXT]),
      .next_tag   (cell_tag[NXT]),
      .head_stamp (cell_stamp[0]),
      .head_tag   (cell_tag[0]),
      .stamp      (cell_stamp[i]),
      .tag        (cell_tag[i])
    );
  end

  ntm_scan #(
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W),
    .TAG_BITS (TAG_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && (opcode == ntm_pkg::OP_QUERY)),
    .target_in  (stamp),
    .tol        (match_tolerance),
    .stale      (stale_age),
    .issue      (issue),
    .pos        (scan_idx[IDX_W-1:0]),
    .e_stamp    (cell_stamp[0]),
    .e_tag      (cell_tag[0]),
    .have       (have),
    .best_pos   (best_pos),
    .best_stamp (best_stamp),
    .best_tag   (best_tag),
    .stale_n    (stale_n)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      match_tolerance <= ntm_pkg::TOL_RESET;
      stale_age       <= ntm_pkg::STALE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ntm_pkg::REG_MATCH_TOLERANCE: match_tolerance <= cfg_data;
        ntm_pkg::REG_STALE_AGE:       stale_age       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      scan_idx  <= '0;
      drop_left <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (opcode == ntm_pkg::OP_PUSH) begin
              if (!full) begin
                count <= count + CNT_W'(1);
              end
              done          <= 1'b1;
              found         <= 1'b0;
              match_tag     <= '0;
              match_stamp   <= '0;
              dropped_count <= full ? ntm_pkg::DROP_W'(1) : '0;
              overflow      <= full;
            end else begin
              scan_idx <= '0;
              state    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end else begin
            // last compare is through the pipe by the next cycle
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drop_left     <= drop_n;
          found         <= have;
          match_tag     <= have ? best_tag_wide[ntm_pkg::TAG_PORT_W-1:0] : '0;
          match_stamp   <= have ? best_stamp : '0;
          dropped_count <= (32'(drop_n) > 32'(ntm_pkg::DROP_MAX)) ?
                           ntm_pkg::DROP_MAX : ntm_pkg::DROP_W'(drop_n);
          overflow      <= 1'b0;
          state         <= S_DROP;
        end
        S_DROP: begin
          if (drop_left != '0) begin
            drop_left <= drop_left - CNT_W'(1);
            count     <= count_dec;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_drop_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DROP) |-> (drop_left <= count))
    else $error("removing more entries than held");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (accept && (opcode == ntm_pkg::OP_PUSH) && full) |=>
      (done && overflow && full))
    else $error("push into full row not flagged");

  a_found_drops: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (dropped_count != '0))
    else $error("match without removal");

endmodule

FILE: hw/rtl/ntm_cell.sv
module ntm_cell #(
  parameter int IDX      = 0,
  parameter int IDX_W    = 6,
  parameter int TAG_BITS = ntm_pkg::TAG_BITS_DEFAULT
) (
  input  logic                       clk,
  input  ntm_pkg::cell_ctrl_t        ctrl,
  input  logic [IDX_W-1:0]           wr_idx,
  input  logic [IDX_W-1:0]           last_idx,
  input  logic [ntm_pkg::STAMP_W-1:0] wr_stamp,
  input  logic [TAG_BITS-1:0]        wr_tag,
  input  logic [ntm_pkg::STAMP_W-1:0] next_stamp,
  input  logic [TAG_BITS-1:0]        next_tag,
  input  logic [ntm_pkg::STAMP_W-1:0] head_stamp,
  input  logic [TAG_BITS-1:0]        head_tag,
  output logic [ntm_pkg::STAMP_W-1:0] stamp,
  output logic [TAG_BITS-1:0]        tag
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [ntm_pkg::STAMP_W-1:0] stamp_next;
  logic [TAG_BITS-1:0]         tag_next;

  always_comb begin
    stamp_next = stamp;
    tag_next   = tag;
    case (ctrl.op)
      ntm_pkg::CELL_SHIFT: begin
        stamp_next = next_stamp;
        tag_next   = next_tag;
      end
      ntm_pkg::CELL_ROTATE: begin
        // entries inside the window move down, the head wraps to the tail
        if (MY_IDX < last_idx) begin
          stamp_next = next_stamp;
          tag_next   = next_tag;
        end else if (MY_IDX == last_idx) begin
          stamp_next = head_stamp;
          tag_next   = head_tag;
        end
      end
      default: begin
      end
    endcase
    if (ctrl.wr_en && (wr_idx == MY_IDX)) begin
      stamp_next = wr_stamp;
      tag_next   = wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    stamp <= stamp_next;
    tag   <= tag_next;
  end

endmodule

FILE: hw/rtl/ntm_scan.sv
module ntm_scan #(
  parameter int IDX_W    = 6,
  parameter int CNT_W    = 7,
  parameter int TAG_BITS = ntm_pkg::TAG_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [ntm_pkg::STAMP_W-1:0] target_in,
  input  logic [ntm_pkg::REG_W-1:0]   tol,
  input  logic [ntm_pkg::REG_W-1:0]   stale,
  input  logic                        issue,
  input  logic [IDX_W-1:0]            pos,
  input  logic [ntm_pkg::STAMP_W-1:0] e_stamp,
  input  logic [TAG_BITS-1:0]         e_tag,
  output logic                        have,
  output logic [IDX_W-1:0]            best_pos,
  output logic [ntm_pkg::STAMP_W-1:0] best_stamp,
  output logic [TAG_BITS-1:0]         best_tag,
  output logic [CNT_W-1:0]            stale_n
);

  localparam int SW = ntm_pkg::STAMP_W;
  localparam int DW = ntm_pkg::DIFF_W;

  // bounds fixed for the whole query
  logic [SW-1:0] target;
  logic [SW:0]   hi_bound;
  logic [SW-1:0] lo_bound;
  logic          lo_en;
  logic [SW-1:0] stale_bound;
  logic          stale_en;

  // compare stage
  logic          a_v;
  logic [IDX_W-1:0] a_pos;
  logic [SW-1:0] a_stamp;
  logic [TAG_BITS-1:0] a_tag;
  logic          a_below;
  logic          a_above;
  logic          a_stale;
  logic [DW-1:0] a_diff;

  // selection stage
  logic [DW-1:0] best_diff;
  logic          stopped;
  logic          stale_run;

  always_ff @(posedge clk) begin
    if (load) begin
      target      <= target_in;
      hi_bound    <= {1'b0, target_in} + (SW+1)'(tol);
      lo_en       <= target_in > SW'(tol);
      lo_bound    <= target_in - SW'(tol);
      stale_en    <= target_in > SW'(stale);
      stale_bound <= target_in - SW'(stale);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || load) begin
      a_v <= 1'b0;
    end else begin
      a_v <= issue;
    end
    a_pos   <= pos;
    a_stamp <= e_stamp;
    a_tag   <= e_tag;
    a_below <= lo_en && (e_stamp < lo_bound);
    a_above <= {1'b0, e_stamp} > hi_bound;
    a_stale <= stale_en && (e_stamp < stale_bound);
    // only the low bits matter: an in-range difference never exceeds the tolerance
    if (e_stamp >= target) begin
      a_diff <= DW'(e_stamp - target);
    end else begin
      a_diff <= DW'(target - e_stamp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have      <= 1'b0;
      stopped   <= 1'b0;
      stale_run <= 1'b0;
      stale_n   <= '0;
    end else if (load) begin
      have      <= 1'b0;
      best_diff <= {1'b0, tol} + DW'(1);
      stopped   <= 1'b0;
      stale_run <= 1'b1;
      stale_n   <= '0;
    end else if (a_v) begin
      // leading run of stale entries
      if (stale_run && a_stale) begin
        stale_n <= stale_n + CNT_W'(1);
      end else begin
        stale_run <= 1'b0;
      end
      if (!stopped) begin
        if (a_above) begin
          stopped <= 1'b1;
        end else if (!a_below && (a_diff < best_diff)) begin
          have       <= 1'b1;
          best_diff  <= a_diff;
          best_pos   <= a_pos;
          best_stamp <= a_stamp;
          best_tag   <= a_tag;
        end
      end
    end
  end

endmodule

FILE: test/ntm_checker.sv
module ntm_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic                            opcode,
  input  logic [ntm_pkg::STAMP_W-1:0]     stamp,
  input  logic [ntm_pkg::TAG_PORT_W-1:0]  tag,
  input  logic                            cfg_write,
  input  logic                            cfg_index,
  input  logic [ntm_pkg::REG_W-1:0]       cfg_data,
  input  logic                            done,
  input  logic                            found,
  input  logic [ntm_pkg::TAG_PORT_W-1:0]  match_tag,
  input  logic [ntm_pkg::STAMP_W-1:0]     match_stamp,
  input  logic [ntm_pkg::DROP_W-1:0]      dropped_count,
  input  logic                            overflow,
  output int                              fail_count,
  output int                              outstanding,
  output int                              results,
  output int                              hits,
  output int                              purges,
  output int                              overflows
);

  localparam int DEPTH      = ntm_pkg::DEPTH_DEFAULT;
  localparam int STAMP_W    = ntm_pkg::STAMP_W;
  localparam int TAG_PORT_W = ntm_pkg::TAG_PORT_W;
  localparam int DROP_W     = ntm_pkg::DROP_W;

  typedef struct packed {
    logic                  found;
    logic [TAG_PORT_W-1:0] tag;
    logic [STAMP_W-1:0]    stamp;
    logic [DROP_W-1:0]     dropped;
    logic                  overflow;
  } outcome_t;

  // shadow of the entry buffer, oldest entry at head
  logic [STAMP_W-1:0]    ring_stamp [DEPTH];
  logic [TAG_PORT_W-1:0] ring_tag   [DEPTH];
  int unsigned           head;
  int unsigned           fill;
  logic [63:0]           tol_reg;
  logic [63:0]           stale_reg;

  outcome_t              expected_q [$];
  outcome_t              want;

  function automatic outcome_t match_or_store(logic op, logic [STAMP_W-1:0] st,
                                              logic [TAG_PORT_W-1:0] tg);
    outcome_t    r;
    logic [63:0] target;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] best;
    int unsigned best_pos;
    int unsigned p;
    int unsigned n;
    bit          have;
    bit          stop;
    r = '0;
    target = {1'b0, st};
    if (op == ntm_pkg::OP_PUSH) begin
      if (fill == DEPTH) begin
        head = (head + 1) % DEPTH;
        fill--;
        r.dropped = DROP_W'(1);
        r.overflow = 1'b1;
      end
      ring_stamp[(head + fill) % DEPTH] = st;
      ring_tag[(head + fill) % DEPTH] = tg;
      fill++;
    end else begin
      best = tol_reg + 1;
      best_pos = 0;
      have = 0;
      stop = 0;
      for (p = 0; p < fill && !stop; p++) begin
        e = {1'b0, ring_stamp[(head + p) % DEPTH]};
        if (e + tol_reg >= target) begin
          if (e > target + tol_reg) begin
            stop = 1;
          end else begin
            d = (e >= target) ? e - target : target - e;
            if (d < best) begin
              best = d;
              best_pos = p;
              have = 1;
            end
          end
        end
      end
      n = 0;
      if (have) begin
        r.found = 1'b1;
        r.tag = ring_tag[(head + best_pos) % DEPTH];
        r.stamp = ring_stamp[(head + best_pos) % DEPTH];
        n = best_pos + 1;
        head = (head + n) % DEPTH;
        fill -= n;
      end else begin
        // no match: purge stale entries from the front
        while (fill > 0 && {1'b0, ring_stamp[head]} + stale_reg < target) begin
          head = (head + 1) % DEPTH;
          fill--;
          n++;
        end
      end
      r.dropped = (n > ntm_pkg::DROP_MAX) ? ntm_pkg::DROP_MAX : n[DROP_W-1:0];
    end
    return r;
  endfunction

  task automatic check_field(string what, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t ntm_checker: %s mismatch, expected %0h, actual %0h",
               $time, what, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head = 0;
      fill = 0;
      tol_reg = {32'd0, ntm_pkg::TOL_RESET};
      stale_reg = {32'd0, ntm_pkg::STALE_RESET};
      expected_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == ntm_pkg::REG_MATCH_TOLERANCE) tol_reg = {32'd0, cfg_data};
        else stale_reg = {32'd0, cfg_data};
      end
      if (done) begin
        results++;
        if (expected_q.size() == 0) begin
          $display("%0t ntm_checker: unexpected result found=%0d tag=%0h stamp=%0h",
                   $time, found, match_tag, match_stamp);
          $display("%0t ntm_checker: unexpected result dropped=%0d overflow=%0d",
                   $time, dropped_count, overflow);
          fail_count++;
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          check_field("found", 64'(want.found), 64'(found));
          check_field("match_tag", 64'(want.tag), 64'(match_tag));
          check_field("match_stamp", 64'(want.stamp), 64'(match_stamp));
          check_field("dropped_count", 64'(want.dropped), 64'(dropped_count));
          check_field("overflow", 64'(want.overflow), 64'(overflow));
        end
      end
      if (start && !busy) begin
        want = match_or_store(opcode, stamp, tag);
        if (want.found) hits++;
        if (opcode == ntm_pkg::OP_QUERY && !want.found && want.dropped != 0) purges++;
        if (want.overflow) overflows++;
        expected_q.insert(expected_q.size(), want);
      end
    end
    outstanding = expected_q.size();
  end

endmodule

FILE: test/tb.sv
module tb;

  localparam int STAMP_W    = ntm_pkg::STAMP_W;
  localparam int TAG_PORT_W = ntm_pkg::TAG_PORT_W;
  localparam int REG_W      = ntm_pkg::REG_W;
  localparam int DROP_W     = ntm_pkg::DROP_W;

  localparam int          TOTAL_RANDOM = 550;
  localparam int          CALM_TAIL    = 60;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam logic [63:0] STAMP_TOP    = 64'h7FFF_FE00_0000_0000;
  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  opcode = ntm_pkg::OP_PUSH;
  logic [STAMP_W-1:0]    stamp = '0;
  logic [TAG_PORT_W-1:0] tag = '0;
  logic                  cfg_write = 1'b0;
  logic                  cfg_index = ntm_pkg::REG_MATCH_TOLERANCE;
  logic [REG_W-1:0]      cfg_data = '0;

  logic                  busy;
  logic                  done;
  logic                  found;
  logic [TAG_PORT_W-1:0] match_tag;
  logic [STAMP_W-1:0]    match_stamp;
  logic [DROP_W-1:0]     dropped_count;
  logic                  overflow;

  int fail_count;
  int outstanding;
  int results;
  int hits;
  int purges;
  int overflows;

  int cycles = 0;
  int sent = 0;
  int settings = 0;
  int goal;
  int run;
  int fill_run;
  int qpct;
  int pick;
  int i;
  bit calm;

  logic [REG_W-1:0]   tol_val;
  logic [REG_W-1:0]   stale_val;
  logic [63:0]        now_ns;
  logic [63:0]        spacing;
  logic [63:0]        tgt;
  logic [STAMP_W-1:0] st;
  logic [STAMP_W-1:0] near_st;
  logic [STAMP_W-1:0] recent [$];

  nearest_timestamp_matcher u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .stamp         (stamp),
    .tag           (tag),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .found         (found),
    .match_tag     (match_tag),
    .match_stamp   (match_stamp),
    .dropped_count (dropped_count),
    .overflow      (overflow)
  );

  ntm_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .stamp         (stamp),
    .tag           (tag),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .found         (found),
    .match_tag     (match_tag),
    .match_stamp   (match_stamp),
    .dropped_count (dropped_count),
    .overflow      (overflow),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .results       (results),
    .hits          (hits),
    .purges        (purges),
    .overflows     (overflows)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("tb: failure");
      $finish;
    end
  end

  // hold the transaction on the ports until the block takes it
  task automatic issue(logic op, logic [STAMP_W-1:0] s, logic [TAG_PORT_W-1:0] t);
    start <= 1'b1;
    opcode <= op;
    stamp <= s;
    tag <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic pause_sender(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [REG_W-1:0] val);
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [REG_W-1:0] pick_setting(logic [REG_W-1:0] dflt);
    case ($urandom_range(0, 5))
      0: return dflt;
      1: return '0;
      2: return '1;
      5: return $urandom;
      default: return $urandom_range(0, 50_000_000);
    endcase
  endfunction

  function automatic logic [STAMP_W-1:0] rand_stamp();
    return STAMP_W'({$urandom, $urandom});
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: empty buffer, stamp extremes, tie, stale purge, skip, early stop
    issue(ntm_pkg::OP_QUERY, 63'd0, 16'h0000);
    issue(ntm_pkg::OP_PUSH, 63'd0, 16'h0000);
    issue(ntm_pkg::OP_PUSH, STAMP_MAX, 16'hFFFF);
    issue(ntm_pkg::OP_QUERY, 63'd0, 16'hFFFF);
    issue(ntm_pkg::OP_QUERY, STAMP_MAX, 16'h0000);
    issue(ntm_pkg::OP_PUSH, 63'd1000, 16'h0001);
    issue(ntm_pkg::OP_PUSH, 63'd3000, 16'h0002);
    issue(ntm_pkg::OP_QUERY, 63'd2000, 16'h0000);
    issue(ntm_pkg::OP_QUERY, 63'd200_003_000, 16'h0000);
    issue(ntm_pkg::OP_PUSH, 63'd0, 16'h1234);
    issue(ntm_pkg::OP_PUSH, 63'd50_000_000, 16'h5678);
    issue(ntm_pkg::OP_QUERY, 63'd50_000_000, 16'h0000);
    issue(ntm_pkg::OP_PUSH, 63'd100_000_000, 16'h9ABC);
    issue(ntm_pkg::OP_QUERY, 63'd50_000_000, 16'h0000);

    // zero tolerance and zero stale age: exact match only
    write_reg(ntm_pkg::REG_MATCH_TOLERANCE, '0);
    write_reg(ntm_pkg::REG_STALE_AGE, '0);
    issue(ntm_pkg::OP_PUSH, 63'd100_000_001, 16'hA5A5);
    issue(ntm_pkg::OP_QUERY, 63'd100_000_001, 16'h0000);
    issue(ntm_pkg::OP_PUSH, 63'd7, 16'h5A5A);
    issue(ntm_pkg::OP_QUERY, 63'd8, 16'h0000);

    // widest registers against the top of the stamp range
    write_reg(ntm_pkg::REG_MATCH_TOLERANCE, '1);
    write_reg(ntm_pkg::REG_STALE_AGE, '1);
    issue(ntm_pkg::OP_PUSH, 63'd5, 16'h0F0F);
    issue(ntm_pkg::OP_PUSH, STAMP_MAX, 16'hF0F0);
    issue(ntm_pkg::OP_QUERY, STAMP_MAX, 16'h0000);
    issue(ntm_pkg::OP_PUSH, 63'd10, 16'h00FF);
    issue(ntm_pkg::OP_QUERY, STAMP_MAX, 16'h0000);
    settings = 3;

    goal = sent + TOTAL_RANDOM;
    now_ns = {1'b0, rand_stamp()};
    while (sent < goal) begin
      tol_val = pick_setting(ntm_pkg::TOL_RESET);
      stale_val = pick_setting(ntm_pkg::STALE_RESET);
      write_reg(ntm_pkg::REG_MATCH_TOLERANCE, tol_val);
      write_reg(ntm_pkg::REG_STALE_AGE, stale_val);
      settings++;
      spacing = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(1, 1000))
                                            : 64'($urandom_range(1000, 30_000_000));
      if ($urandom_range(0, 3) == 0) now_ns = {1'b0, rand_stamp()};
      else now_ns += 64'($urandom);
      if (now_ns > STAMP_TOP) now_ns = 64'($urandom);
      calm = ($urandom_range(0, 2) == 0);
      run = $urandom_range(30, 70);
      // some phases open with a long push run to wrap the buffer
      fill_run = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 72) : 0;
      qpct = $urandom_range(20, 50);
      for (i = 0; i < run + fill_run && sent < goal; i++) begin
        if (!calm && sent < goal - CALM_TAIL && $urandom_range(0, 3) == 0)
          pause_sender($urandom_range(1, 11));
        if (i < fill_run || $urandom_range(0, 99) >= qpct) begin
          now_ns += spacing / 2 + 64'($urandom_range(0, 32'(spacing)));
          // occasional out-of-order entry
          st = ($urandom_range(0, 9) == 0) ? rand_stamp() : now_ns[STAMP_W-1:0];
          recent.insert(recent.size(), st);
          if (recent.size() > 8) recent.delete(0);
          issue(ntm_pkg::OP_PUSH, st, TAG_PORT_W'($urandom));
        end else begin
          pick = $urandom_range(0, 99);
          near_st = (recent.size() > 0) ? recent[$urandom_range(0, recent.size() - 1)]
                                        : now_ns[STAMP_W-1:0];
          if (pick < 20) begin
            tgt = {1'b0, near_st};
          end else if (pick < 70) begin
            tgt = {1'b0, near_st} + 64'($urandom_range(0, 32'(2 * spacing)));
            tgt = (tgt < spacing) ? 64'd0 : tgt - spacing;
          end else if (pick < 88) begin
            tgt = now_ns + 64'(stale_val) + 64'($urandom_range(1, 32'(2 * spacing)));
          end else begin
            tgt = {1'b0, rand_stamp()};
          end
          issue(ntm_pkg::OP_QUERY, tgt[STAMP_W-1:0], TAG_PORT_W'($urandom));
        end
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);

    $display("tb: %0d transactions over %0d register settings, %0d results checked",
             sent, settings, results);
    $display("tb: %0d matched queries, %0d stale purges, %0d overflow pushes",
             hits, purges, overflows);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ntm_pkg.sv
hw/rtl/ntm_cell.sv
hw/rtl/ntm_scan.sv
hw/rtl/nearest_timestamp_matcher.sv
test/ntm_checker.sv
test/tb.sv
